### sv/hvd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the halfspace violation distance unit.
package hvd_pkg;

    // Input item: one coordinate, one coefficient or one facet bound.
    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         dim_index;
        logic signed [31:0] value;
        logic               last_facet;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [62:0] distance_sq;
        logic        zero_norm_flag;
        logic        saturated_flag;
    } t_out_item;

    // Item modes.
    localparam logic [1:0] MODE_POINT = 2'd0;
    localparam logic [1:0] MODE_COEF  = 2'd1;
    localparam logic [1:0] MODE_BOUND = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_UNIVERSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_EMPTY    = 2'd1;

    // Arithmetic widths and limits.
    localparam int MUL_W     = 33;
    localparam int SUM_W     = 48;
    localparam int DEN_W     = 64;
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [SUM_W-1:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] ROOT_MAX = 48'd3037000499;
    localparam logic [62:0]      RES_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;

    // Main sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DOT,
        ST_ACC_DOT,
        ST_ACC_NORM,
        ST_DIFF,
        ST_DIV,
        ST_SUM,
        ST_SQ_MUL,
        ST_SQ
    } t_state;

    // Serial divider sequencer.
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

### sv/hvd_pmem.sv
`timescale 1ns / 1ps
// Point coordinate store: one write port, one registered read port.
module hvd_pmem
    import hvd_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic signed [31:0]      i_wr_data,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output logic signed [31:0]      o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/hvd_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module hvd_mul
    import hvd_pkg::*;
(
    input  logic                        i_clk,
    input  logic signed [MUL_W-1:0]     i_a,
    input  logic signed [MUL_W-1:0]     i_b,
    output logic signed [2*MUL_W-1:0]   o_p
);

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### sv/hvd_div.sv
`timescale 1ns / 1ps
// Restoring serial divider: floor(num * 2^16 / den), one quotient bit per cycle.
module hvd_div
    import hvd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [62:0]         i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic [SUM_W-1:0]    o_quo,
    output t_div_stat           o_stat
);

    t_div_state             r_state, n_state;
    logic [DEN_W-1:0]       r_rem, n_rem;
    logic [DEN_W-1:0]       r_den, n_den;
    logic [SUM_W-1:0]       r_shift, n_shift;
    logic [SUM_W-1:0]       r_quo, n_quo;
    logic                   r_ovf, n_ovf;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;

    logic [DEN_W:0]         try_rem;
    logic [DEN_W:0]         sub_rem;
    logic                   fits;

    assign try_rem = {r_rem, r_shift[SUM_W-1]};
    assign sub_rem = try_rem - {1'b0, r_den};
    assign fits    = (try_rem >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_shift <= n_shift;
        r_quo   <= n_quo;
        r_ovf   <= n_ovf;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_den   = r_den;
        n_shift = r_shift;
        n_quo   = r_quo;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    // high part of the scaled numerator is the first partial remainder
                    n_rem   = {33'd0, i_num[62:32]};
                    n_shift = {i_num[31:0], 16'd0};
                    n_den   = i_den;
                    n_quo   = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = DIV_CNT_W'(DIV_STEPS - 1);
                    n_state = DV_CHECK;
                end
            end
            DV_CHECK: begin
                // quotient would not fit in 48 bits
                if (r_rem >= r_den) begin
                    n_ovf   = 1'b1;
                    n_state = DV_DONE;
                end else begin
                    n_state = DV_RUN;
                end
            end
            DV_RUN: begin
                n_rem   = fits ? sub_rem[DEN_W-1:0] : try_rem[DEN_W-1:0];
                n_shift = {r_shift[SUM_W-2:0], 1'b0};
                n_quo   = {r_quo[SUM_W-2:0], fits};
                if (r_cnt == '0) begin
                    n_state = DV_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    assign o_quo       = r_quo;
    assign o_stat.done = (r_state == DV_DONE);
    assign o_stat.ovf  = r_ovf;

endmodule

### sv/halfspace_violation_distance_unit.sv
`timescale 1ns / 1ps
// Top level: sequencer, accumulators and result register of the violation distance unit.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   result   out        o_out_valid / i_out_ready  o_out_data (t_out_item)
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A point item is written to the point store; a coefficient item reads the
// memory, then uses the shared multiplier twice for a.x and a.a. A bound item
// runs the 48-step serial divider when the facet is violated and the norm is
// nonzero; on the last facet the sum is then squared on the shared multiplier.
// Reset is synchronous, active low; the point store is not cleared.
// A held result stalls the last facet only until the output register frees.
module halfspace_violation_distance_unit
    import hvd_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_state                     r_state, n_state;
    logic                       r_universe, r_empty;
    logic signed [31:0]         r_val;
    logic                       r_last;
    logic [63:0]                r_dot, n_dot;
    logic [DEN_W-1:0]           r_norm, n_norm;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic                       r_zn, n_zn;
    logic                       r_sat, n_sat;
    logic [SUM_W-1:0]           r_term, n_term;
    logic                       r_root_ovf, n_root_ovf;
    logic                       r_out_valid, n_out_valid;
    t_out_item                  r_out, n_out;

    logic                       in_acc;
    logic                       in_range;
    logic                       wr_en, rd_en;
    logic [ADDR_W-1:0]          addr;
    logic signed [31:0]         pt;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  prod;
    logic signed [MUL_W-1:0]    mag;

    logic                       div_start;
    logic [SUM_W-1:0]           quo;
    t_div_stat                  div_stat;

    logic [64:0]                dot_full;
    logic [64:0]                norm_full;
    logic [64:0]                bnd_q;
    logic [64:0]                diff_full;
    logic [63:0]                diff;
    logic                       diff_ovf;
    logic                       diff_pos;
    logic [SUM_W:0]             sum_full;
    logic                       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_range = (32'(i_in_data.dim_index) < MAX_DIM);
    assign addr     = ADDR_W'(i_in_data.dim_index);
    assign wr_en    = in_acc && (i_in_data.mode == MODE_POINT) && in_range;
    assign rd_en    = in_acc && (i_in_data.mode == MODE_COEF) && in_range;

    hvd_pmem #(
        .DEPTH  (MAX_DIM),
        .ADDR_W (ADDR_W)
    ) u_pmem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (pt)
    );

    hvd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    hvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff[62:0]),
        .i_den   (r_norm),
        .o_quo   (quo),
        .o_stat  (div_stat)
    );

    // |value| in 33 bits so that the most negative value squares correctly
    assign mag = r_val[31] ? -{r_val[31], r_val} : {r_val[31], r_val};

    assign dot_full  = {r_dot[63], r_dot} + {prod[63], prod[63:0]};
    assign norm_full = {1'b0, r_norm} + {1'b0, prod[63:0]};

    // bound widened to Q32.32
    assign bnd_q     = {{17{r_val[31]}}, r_val, 16'd0};
    assign diff_full = {r_dot[63], r_dot} - bnd_q;
    assign diff_ovf  = (diff_full[64] != diff_full[63]);

    always_comb begin
        if (diff_ovf) begin
            diff = diff_full[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            diff = diff_full[63:0];
        end
    end

    assign diff_pos = !diff[63] && (diff != '0);
    assign sum_full = {1'b0, r_sum} + {1'b0, r_term};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_universe  <= 1'b1;
            r_empty     <= 1'b0;
            r_dot       <= '0;
            r_norm      <= '0;
            r_sum       <= '0;
            r_zn        <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dot       <= n_dot;
            r_norm      <= n_norm;
            r_sum       <= n_sum;
            r_zn        <= n_zn;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_IS_UNIVERSE: r_universe <= i_cfg_data[0];
                    CFG_IS_EMPTY:    r_empty    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_val  <= i_in_data.value;
            r_last <= i_in_data.last_facet;
        end
        r_term     <= n_term;
        r_root_ovf <= n_root_ovf;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_dot       = r_dot;
        n_norm      = r_norm;
        n_sum       = r_sum;
        n_zn        = r_zn;
        n_sat       = r_sat;
        n_term      = r_term;
        n_root_ovf  = r_root_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (rd_en) begin
                    n_state = ST_MUL_DOT;
                end else if (in_acc && (i_in_data.mode == MODE_BOUND)) begin
                    n_state = ST_DIFF;
                end
            end
            ST_MUL_DOT: begin
                mul_a   = {pt[31], pt};
                mul_b   = {r_val[31], r_val};
                n_state = ST_ACC_DOT;
            end
            ST_ACC_DOT: begin
                mul_a = mag;
                mul_b = mag;
                if (dot_full[64] != dot_full[63]) begin
                    n_dot = dot_full[64] ? 64'h8000_0000_0000_0000
                                         : 64'h7FFF_FFFF_FFFF_FFFF;
                    n_sat = 1'b1;
                end else begin
                    n_dot = dot_full[63:0];
                end
                n_state = ST_ACC_NORM;
            end
            ST_ACC_NORM: begin
                if (norm_full[64]) begin
                    n_norm = '1;
                    n_sat  = 1'b1;
                end else begin
                    n_norm = norm_full[63:0];
                end
                n_state = ST_IDLE;
            end
            ST_DIFF: begin
                n_term = '0;
                if (diff_ovf) begin
                    n_sat = 1'b1;
                end
                if (diff_pos && (r_norm == '0)) begin
                    n_term  = SUM_MAX;
                    n_zn    = 1'b1;
                    n_state = ST_SUM;
                end else if (diff_pos) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_term = div_stat.ovf ? SUM_MAX : quo;
                    if (div_stat.ovf) begin
                        n_sat = 1'b1;
                    end
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_full[SUM_W]) begin
                    n_sum = SUM_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_sum = sum_full[SUM_W-1:0];
                end
                n_dot   = '0;
                n_norm  = '0;
                n_state = r_last ? ST_SQ_MUL : ST_IDLE;
            end
            ST_SQ_MUL: begin
                mul_a      = {1'b0, r_sum[31:0]};
                mul_b      = {1'b0, r_sum[31:0]};
                n_root_ovf = (r_sum > ROOT_MAX);
                n_state    = ST_SQ;
            end
            ST_SQ: begin
                // hold the operands so the product stays while the output is busy
                mul_a = {1'b0, r_sum[31:0]};
                mul_b = {1'b0, r_sum[31:0]};
                if (out_free) begin
                    if (r_universe || r_empty) begin
                        n_out.distance_sq    = '0;
                        n_out.zero_norm_flag = 1'b0;
                        n_out.saturated_flag = 1'b0;
                    end else if (r_root_ovf) begin
                        n_out.distance_sq    = RES_MAX;
                        n_out.zero_norm_flag = r_zn;
                        n_out.saturated_flag = 1'b1;
                    end else begin
                        n_out.distance_sq    = prod[62:0];
                        n_out.zero_norm_flag = r_zn;
                        n_out.saturated_flag = r_sat;
                    end
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_zn        = 1'b0;
                    n_sat       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
